/* hdl/acf_pkg.sv */
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types, codes and constants of the ACIA receive ring and registers.
// ----------------------------------------------------------------------------
package acf_pkg;

  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int PERIOD_W = 14;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 14'd10000;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] REG_DATA    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  localparam logic [7:0] STATUS_VALUE = 8'h10;
  localparam logic [7:0] CHAR_DEL     = 8'h7F;
  localparam logic [7:0] CHAR_BS      = 8'h08;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef logic [RING_AW-1:0] ring_ptr_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head;
  } ring_status_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       irq_pulse;
    logic       key_accepted;
  } result_t;

  function automatic logic [7:0] translate_key(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CHAR_DEL) r = CHAR_BS;
    else if (c == CHAR_LF) r = CHAR_CR;
    return r;
  endfunction

  function automatic ring_ptr_t ring_next(input ring_ptr_t p);
    ring_ptr_t r;
    if (p == ring_ptr_t'(RING_DEPTH - 1)) r = '0;
    else r = p + ring_ptr_t'(1);
    return r;
  endfunction

endpackage

/* hdl/acf_ring.sv */
// ----------------------------------------------------------------------------
// acf_ring
// Receive ring storage with read and write pointers; one slot kept free.
// ----------------------------------------------------------------------------
module acf_ring import acf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [7:0]   rx_char,
  input  logic         pop,
  output ring_status_t status
);

  logic [7:0] ring [RING_DEPTH];
  ring_ptr_t  read_pointer;
  ring_ptr_t  write_pointer;

  always_comb begin
    status.empty = (read_pointer == write_pointer);
    status.full  = (ring_next(write_pointer) == read_pointer);
    status.head  = ring[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring[write_pointer] <= rx_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
    end else begin
      if (push) write_pointer <= ring_next(write_pointer);
      if (pop) read_pointer <= ring_next(read_pointer);
    end
  end

endmodule

/* hdl/acf_pacer.sv */
// ----------------------------------------------------------------------------
// acf_pacer
// Interrupt period register and the pacing counter that wraps at the period.
// ----------------------------------------------------------------------------
module acf_pacer import acf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [PERIOD_W-1:0] cfg_write_data,
  input  logic                tick,
  output logic                counter_zero
);

  logic [PERIOD_W-1:0] interrupt_period;
  logic [PERIOD_W-1:0] pacing_counter;
  logic [PERIOD_W-1:0] pacing_counter_next;
  logic [PERIOD_W:0]   count_plus;

  assign counter_zero = (pacing_counter == '0);
  assign count_plus   = {1'b0, pacing_counter} + (PERIOD_W+1)'(1);

  always_comb begin
    if (count_plus >= {1'b0, interrupt_period}) pacing_counter_next = '0;
    else pacing_counter_next = count_plus[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_period <= PERIOD_RESET;
      pacing_counter   <= '0;
    end else begin
      if (cfg_write_en) interrupt_period <= cfg_write_data;
      if (tick) pacing_counter <= pacing_counter_next;
    end
  end

endmodule

/* hdl/acf_out_queue.sv */
// ----------------------------------------------------------------------------
// acf_out_queue
// Two-entry result buffer that decouples input ready from output ready.
// ----------------------------------------------------------------------------
module acf_out_queue import acf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] count_after_pop;
  logic       pop;

  assign out_valid       = (count != 2'd0);
  assign space           = (count != 2'd2);
  assign head            = slot0;
  assign pop             = out_valid && out_ready;
  assign count_after_pop = count - {1'b0, pop};
  assign count_next      = count_after_pop + {1'b0, push};

  always_ff @(posedge clk) begin
    if (push && count_after_pop == 2'd0) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && count_after_pop != 2'd0) slot1 <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* hdl/acia_receive_fifo_registers.sv */
// ----------------------------------------------------------------------------
// acia_receive_fifo_registers
// Simplified serial ACIA: receive ring, register reads and writes, paced irq.
//
//   channel   signals                                      direction
//   input     in_valid in_ready opcode reg_addr            in
//             write_data key_char
//   output    out_valid out_ready read_data tx_valid       out
//             tx_char irq_pulse key_accepted
//   config    cfg_write_en cfg_write_data                  in
//
// one item per cycle while in_ready is high; the result is registered in a
// two-entry result buffer, which keeps in_ready high while one result
// waits; in_ready falls only with two results waiting. rst clears the
// pointers, the pacing counter and the result buffer and sets the period
// to 10000; ring contents are not cleared.
// ----------------------------------------------------------------------------
module acia_receive_fifo_registers import acf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [1:0]          reg_addr,
  input  logic [7:0]          write_data,
  input  logic [7:0]          key_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          read_data,
  output logic                tx_valid,
  output logic [7:0]          tx_char,
  output logic                irq_pulse,
  output logic                key_accepted,
  input  logic                cfg_write_en,
  input  logic [PERIOD_W-1:0] cfg_write_data
);

  ring_status_t ring_stat;
  result_t      res;
  result_t      head;
  logic         xfer;
  logic         push;
  logic         pop;
  logic         tick;
  logic         counter_zero;

  assign xfer = in_valid && in_ready;
  assign push = xfer && (opcode == OP_KEY) && !ring_stat.full;
  assign pop  = xfer && (opcode == OP_READ) && (reg_addr == REG_DATA) && !ring_stat.empty;
  assign tick = xfer && (opcode == OP_TICK);

  acf_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_char (translate_key(key_char)),
    .pop     (pop),
    .status  (ring_stat)
  );

  acf_pacer u_pacer (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .tick           (tick),
    .counter_zero   (counter_zero)
  );

  always_comb begin
    res = '0;
    unique case (opcode)
      OP_KEY: begin
        res.key_accepted = !ring_stat.full;
      end
      OP_READ: begin
        unique case (reg_addr)
          REG_DATA:    res.read_data = ring_stat.empty ? 8'h00 : ring_stat.head;
          REG_STATUS:  res.read_data = STATUS_VALUE;
          REG_COMMAND,
          REG_CONTROL: res.read_data = 8'h00;
          default:     res.read_data = 8'h00;
        endcase
      end
      OP_WRITE: begin
        if (reg_addr == REG_DATA) begin
          res.tx_valid = 1'b1;
          res.tx_char  = write_data;
        end
      end
      OP_TICK: begin
        res.irq_pulse = counter_zero && !ring_stat.empty;
      end
      default: res = '0;
    endcase
  end

  acf_out_queue u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (xfer),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign read_data    = head.read_data;
  assign tx_valid     = head.tx_valid;
  assign tx_char      = head.tx_char;
  assign irq_pulse    = head.irq_pulse;
  assign key_accepted = head.key_accepted;

endmodule

/* hdl/acf_checker.sv */
// ----------------------------------------------------------------------------
// acf_checker
// Port-level checks of the ACIA block, bound to the top level.
// ----------------------------------------------------------------------------
module acf_checker import acf_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          opcode,
  input logic [1:0]          reg_addr,
  input logic [7:0]          write_data,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          read_data,
  input logic                tx_valid,
  input logic [7:0]          tx_char,
  input logic                irq_pulse,
  input logic                key_accepted
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_char))
    else $error("stalled result changed");

  a_tx_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && opcode == OP_WRITE && reg_addr == REG_DATA
    |=> out_valid && tx_valid && tx_char == $past(write_data) && !key_accepted)
    else $error("data write did not transmit");

  a_status: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && opcode == OP_READ && reg_addr == REG_STATUS
    |=> out_valid && read_data == STATUS_VALUE && !irq_pulse && !tx_valid)
    else $error("status read wrong");

endmodule

bind acia_receive_fifo_registers acf_checker u_acf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .opcode       (opcode),
  .reg_addr     (reg_addr),
  .write_data   (write_data),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .tx_valid     (tx_valid),
  .tx_char      (tx_char),
  .irq_pulse    (irq_pulse),
  .key_accepted (key_accepted)
);

/* sim/tb_acia_receive_fifo_registers.sv */
// ----------------------------------------------------------------------------
// tb_acia_receive_fifo_registers
// Self-checking bench for the ACIA receive ring and register block. A queue
// of bus accesses, keys and ticks feeds a valid/ready driver; every transfer
// is run through a local model of the ring, registers and pacing counter,
// and a monitor compares each returned result field by field. Directed
// cases come first: empty read, all registers, key translation, a full ring
// and the smallest periods. Random traffic then runs under several periods
// and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_acia_receive_fifo_registers import acf_pkg::*; ();

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] key_char;
  } acia_access_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          opcode = '0;
  logic [1:0]          reg_addr = '0;
  logic [7:0]          write_data = '0;
  logic [7:0]          key_char = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          read_data;
  logic                tx_valid;
  logic [7:0]          tx_char;
  logic                irq_pulse;
  logic                key_accepted;
  logic                cfg_write_en = 1'b0;
  logic [PERIOD_W-1:0] cfg_write_data = '0;

  acia_access_t access_queue[$];
  acia_access_t held_access;
  bit           access_held = 1'b0;
  result_t      response_queue[$];
  result_t      next_response;
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  // model state
  logic [7:0]          rx_ring [RING_DEPTH];
  ring_ptr_t           rx_rd = '0;
  ring_ptr_t           rx_wr = '0;
  logic [PERIOD_W-1:0] pace_cnt = '0;
  logic [PERIOD_W-1:0] pace_period = PERIOD_RESET;

  acia_receive_fifo_registers dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .reg_addr       (reg_addr),
    .write_data     (write_data),
    .key_char       (key_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .tx_valid       (tx_valid),
    .tx_char        (tx_char),
    .irq_pulse      (irq_pulse),
    .key_accepted   (key_accepted),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ring_ptr_t rx_next(input ring_ptr_t p);
    return ring_ptr_t'((int'(p) + 1) % RING_DEPTH);
  endfunction

  function automatic result_t acia_response(input acia_access_t a);
    result_t r;
    r = '0;
    case (a.opcode)
      OP_KEY: begin
        if (rx_next(rx_wr) != rx_rd) begin
          if (a.key_char == CHAR_DEL) rx_ring[rx_wr] = CHAR_BS;
          else if (a.key_char == CHAR_LF) rx_ring[rx_wr] = CHAR_CR;
          else rx_ring[rx_wr] = a.key_char;
          rx_wr = rx_next(rx_wr);
          r.key_accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (a.reg_addr == REG_DATA) begin
          if (rx_rd != rx_wr) begin
            r.read_data = rx_ring[rx_rd];
            rx_rd = rx_next(rx_rd);
          end
        end else if (a.reg_addr == REG_STATUS) begin
          r.read_data = STATUS_VALUE;
        end
      end
      OP_WRITE: begin
        if (a.reg_addr == REG_DATA) begin
          r.tx_valid = 1'b1;
          r.tx_char = a.write_data;
        end
      end
      default: begin
        if (pace_cnt == '0 && rx_rd != rx_wr) r.irq_pulse = 1'b1;
        // wraps whenever the next count reaches or passes the period
        if (int'(pace_cnt) + 1 >= int'(pace_period)) pace_cnt = '0;
        else pace_cnt = pace_cnt + PERIOD_W'(1);
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        response_queue.push_back(acia_response(held_access));
        access_held = 1'b0;
      end
      if (!in_valid || in_ready) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_access = access_queue.pop_front();
          access_held = 1'b1;
          opcode     <= held_access.opcode;
          reg_addr   <= held_access.reg_addr;
          write_data <= held_access.write_data;
          key_char   <= held_access.key_char;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (response_queue.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          next_response = response_queue.pop_front();
          if (read_data !== next_response.read_data)
            flag_mismatch($sformatf("read_data got %h want %h", read_data,
                                    next_response.read_data));
          if (tx_valid !== next_response.tx_valid)
            flag_mismatch($sformatf("tx_valid got %b want %b", tx_valid,
                                    next_response.tx_valid));
          if (tx_char !== next_response.tx_char)
            flag_mismatch($sformatf("tx_char got %h want %h", tx_char,
                                    next_response.tx_char));
          if (irq_pulse !== next_response.irq_pulse)
            flag_mismatch($sformatf("irq_pulse got %b want %b", irq_pulse,
                                    next_response.irq_pulse));
          if (key_accepted !== next_response.key_accepted)
            flag_mismatch($sformatf("key_accepted got %b want %b", key_accepted,
                                    next_response.key_accepted));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_access(input logic [1:0] op, input logic [1:0] ra,
                            input logic [7:0] wd, input logic [7:0] kc);
    acia_access_t a;
    a.opcode = op;
    a.reg_addr = ra;
    a.write_data = wd;
    a.key_char = kc;
    access_queue.push_back(a);
  endtask

  function automatic logic [7:0] random_key();
    case ($urandom_range(5))
      0: return CHAR_DEL;
      1: return CHAR_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // key bursts fill the ring, read bursts drain it, the rest is mixed traffic
  task automatic queue_random_traffic(input int count);
    int left;
    int run;
    int kind;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(9);
      run = (kind < 5) ? $urandom_range(1, 18) : 1;
      if (run > left) run = left;
      repeat (run) begin
        if (kind < 3)
          add_access(OP_KEY, 2'($urandom_range(3)), 8'($urandom_range(255)), random_key());
        else if (kind < 5)
          add_access(OP_READ, REG_DATA, 8'($urandom_range(255)), random_key());
        else
          add_access(2'($urandom_range(3)), 2'($urandom_range(3)),
                     8'($urandom_range(255)), random_key());
      end
      left -= run;
    end
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || access_held || response_queue.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    pace_period = value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [PERIOD_W-1:0] period, input int send_pct,
                           input int recv_pct, input int count);
    write_period(period);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random_traffic(count);
    wait_drained();
  endtask

  initial begin
    #800000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 62;

    // empty ring, every register, transmit and a tick
    add_access(OP_READ, REG_DATA, 8'h00, 8'h00);
    add_access(OP_READ, REG_STATUS, 8'hFF, 8'hFF);
    add_access(OP_READ, REG_COMMAND, 8'h00, 8'h00);
    add_access(OP_READ, REG_CONTROL, 8'hFF, 8'hFF);
    add_access(OP_WRITE, REG_DATA, 8'h00, 8'hFF);
    add_access(OP_WRITE, REG_DATA, 8'hFF, 8'h00);
    add_access(OP_WRITE, REG_COMMAND, 8'hA5, 8'h5A);
    add_access(OP_TICK, REG_CONTROL, 8'hFF, 8'hFF);
    // translated keys, extremes, then fill the ring and overflow it
    add_access(OP_KEY, REG_DATA, 8'h00, CHAR_DEL);
    add_access(OP_KEY, REG_STATUS, 8'h00, CHAR_LF);
    add_access(OP_KEY, REG_COMMAND, 8'h00, 8'h00);
    add_access(OP_KEY, REG_CONTROL, 8'h00, 8'hFF);
    for (int i = 0; i < RING_DEPTH - 5; i++)
      add_access(OP_KEY, REG_DATA, 8'h00, 8'($urandom_range(255)));
    add_access(OP_KEY, REG_DATA, 8'h00, 8'h33);
    wait_drained();

    // smallest periods: every tick with data waiting raises irq
    write_period(1);
    add_access(OP_TICK, REG_DATA, 8'h00, 8'h00);
    add_access(OP_READ, REG_DATA, 8'h00, 8'h00);
    add_access(OP_TICK, REG_DATA, 8'h00, 8'h00);
    wait_drained();
    write_period(0);
    add_access(OP_TICK, REG_DATA, 8'h00, 8'h00);
    add_access(OP_TICK, REG_DATA, 8'h00, 8'h00);
    wait_drained();

    run_phase(5, 17, 62, 200);
    run_phase(14'h3FFF, 17, 62, 150);
    // period drops below the running count
    run_phase(3, 62, 17, 200);
    run_phase(1, 62, 17, 150);
    run_phase(7, 0, 0, 200);
    run_phase(2, 0, 0, 150);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && response_queue.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
